// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top level of the matrix multiply engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed: label");
// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed: label");
`else
`define ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

// ===== hw/rtl/mme_pkg.sv =====
// Types and constants shared by the matrix multiply engine modules.
`default_nettype none
package mme_pkg;

   // Accumulator width: eight exact 64-bit products plus sign headroom.
   localparam int ACC_W  = 68;
   // Fraction bits of the Q16.16 format.
   localparam int FRAC_W = 16;

   // Element of A travelling down the chain of cells.
   typedef struct packed {
      logic              valid;
      logic              first;
      logic              last;
      logic [2:0]        j;
      logic signed [31:0] a;
   } link_type;

   // Write of one element of B into a cell's local column.
   typedef struct packed {
      logic              we;
      logic [2:0]        row;
      logic signed [31:0] data;
   } b_wr_type;

   // Dot product held by a cell, with a pulse when it completes.
   typedef struct packed {
      logic                    done;
      logic signed [ACC_W-1:0] acc;
   } cell_res_type;

endpackage
`default_nettype wire

// ===== hw/rtl/mme_cell.sv =====
// One cell of the chain: holds a column of B and accumulates one element of C.
`default_nettype none
module mme_cell import mme_pkg::*; #(
   parameter int MAX_DIM = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  b_wr_type     b_wr,
   input  link_type     link_in,
   output link_type     link_out,
   output cell_res_type res
);
   localparam int IDXW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   logic signed [31:0]      bcol_ff [MAX_DIM];
   link_type                link_ff;
   logic signed [63:0]      prod_ff;
   logic                    pv_ff, pfirst_ff, plast_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic                    done_ff;
   logic signed [31:0]      b_sel;

   // Local column of B, written while loading.
   always_ff @(posedge clock) begin
      if (b_wr.we) begin
         bcol_ff[IDXW'(b_wr.row)] <= b_wr.data;
      end
   end

   assign b_sel = bcol_ff[IDXW'(link_in.j)];

   // Pass the element of A on to the neighbor and form the product.
   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.valid <= 1'b0;
         pv_ff         <= 1'b0;
      end else begin
         link_ff.valid <= link_in.valid;
         pv_ff         <= link_in.valid;
      end
      link_ff.first <= link_in.first;
      link_ff.last  <= link_in.last;
      link_ff.j     <= link_in.j;
      link_ff.a     <= link_in.a;
      prod_ff       <= link_in.a * b_sel;
      pfirst_ff     <= link_in.first;
      plast_ff      <= link_in.last;
   end

   // Exact accumulation; the sum holds until the next row starts.
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= pv_ff && plast_ff;
      end
      if (pv_ff) begin
         if (pfirst_ff) begin
            acc_ff <= ACC_W'(prod_ff);
         end else begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   assign link_out = link_ff;
   assign res.done = done_ff;
   assign res.acc  = acc_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/matrix_multiply_engine_top.sv =====
// Top level of the matrix multiply engine: loading, sequencing and output.
// Elements load one item per cycle while the input is not stalled. An item
// with start_after set stalls the input while C is computed one row at a
// time: the row of A is read from memory one element per cycle and walks
// down a chain of cells, cell k holding column k of B and its own
// multiplier and accumulator. Each row passes through the chain and is
// then emitted, held back whenever the output stalls. After the product
// the input stays stalled until the chain has drained, so that a new run
// never sees a stale completion. The stores need no clearing after reset.
`default_nettype none
module matrix_multiply_engine_top import mme_pkg::*; #(
   parameter int MAX_DIM = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic [2:0]         req_row_index,
   input  logic [2:0]         req_col_index,
   input  logic signed [31:0] req_element_value,
   input  logic               req_start_after,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_out_row,
   output logic [2:0]         rsp_out_col,
   output logic signed [31:0] rsp_product_value,
   output logic               rsp_saturated,
   output logic               rsp_last_of_run,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [3:0]         csr_data
);
`include "assert_macros.svh"

   localparam int IDXW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DCAP = (MAX_DIM < 8) ? MAX_DIM : 8;
   localparam int CW   = (DCAP > 1) ? $clog2(DCAP) : 1;

   localparam logic [1:0] REG_ROWS_A = 2'd0;
   localparam logic [1:0] REG_INNER  = 2'd1;
   localparam logic [1:0] REG_COLS_B = 2'd2;

   typedef enum logic [1:0] {S_LOAD, S_FEED, S_WAIT, S_EMIT} state_type;

   state_type          state_ff;
   logic [3:0]         rows_a_ff, inner_dim_ff, cols_b_ff;
   logic [3:0]         n_ff, p_ff, l_ff;
   logic [3:0]         n_in, p_in, l_in;
   logic [2:0]         i_ff, j_ff, k_ff;
   logic signed [31:0] amem [2**(2*IDXW)];
   logic signed [31:0] a_rd_ff;
   link_type           inj_ff;
   link_type           link [DCAP+1];
   cell_res_type       res [DCAP];
   logic [DCAP-1:0]    done_vec;
   logic [DCAP:0]      link_busy;
   logic               chain_busy;
   logic               accept, in_range;
   logic               rsp_valid_ff, rsp_sat_ff, rsp_last_ff;
   logic [2:0]         rsp_row_ff, rsp_col_ff;
   logic signed [31:0] rsp_val_ff;
   logic               out_load, row_done, run_done;
   logic signed [ACC_W-1:0] sel_acc, sh_acc;
   logic signed [31:0] sat_val;
   logic               sat_flag;

   // Clamp a dimension register to the range the chain supports.
   function automatic logic [3:0] eff_dim(input logic [3:0] v);
      if (v == 4'd0) begin
         return 4'd1;
      end else if (32'(v) > DCAP) begin
         return 4'(DCAP);
      end
      return v;
   endfunction

   assign n_in = eff_dim(rows_a_ff);
   assign p_in = eff_dim(inner_dim_ff);
   assign l_in = eff_dim(cols_b_ff);

   // The input waits while a product runs or the chain still carries data.
   assign chain_busy = (|link_busy) || (|done_vec);
   assign req_stall = (state_ff != S_LOAD) || chain_busy;
   assign accept    = req_valid && !req_stall;
   assign in_range  = (32'(req_row_index) < MAX_DIM) && (32'(req_col_index) < MAX_DIM);
   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= 4'd8;
         inner_dim_ff <= 4'd8;
         cols_b_ff    <= 4'd8;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_ROWS_A: rows_a_ff    <= csr_data;
            REG_INNER:  inner_dim_ff <= csr_data;
            REG_COLS_B: cols_b_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // Store of A, written while loading and read one element per cycle.
   always_ff @(posedge clock) begin
      if (accept && in_range && !req_kind) begin
         amem[{IDXW'(req_row_index), IDXW'(req_col_index)}] <= req_element_value;
      end
      a_rd_ff <= amem[{IDXW'(i_ff), IDXW'(j_ff)}];
   end

   assign link[0].valid = inj_ff.valid;
   assign link[0].first = inj_ff.first;
   assign link[0].last  = inj_ff.last;
   assign link[0].j     = inj_ff.j;
   assign link[0].a     = a_rd_ff;

   // Chain of cells, one per column of the result.
   for (genvar c = 0; c < DCAP; c++) begin : g_cell
      b_wr_type bw;
      assign bw.we   = accept && in_range && req_kind && (32'(req_col_index) == c);
      assign bw.row  = req_row_index;
      assign bw.data = req_element_value;
      mme_cell #(.MAX_DIM(MAX_DIM)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .b_wr     (bw),
         .link_in  (link[c]),
         .link_out (link[c+1]),
         .res      (res[c])
      );
      assign done_vec[c]  = res[c].done;
      assign link_busy[c] = link[c].valid;
   end
   assign link_busy[DCAP] = link[DCAP].valid;

   // Scale and saturate the selected dot product.
   assign sel_acc  = res[CW'(k_ff)].acc;
   assign sh_acc   = sel_acc >>> FRAC_W;
   always_comb begin
      sat_flag = 1'b1;
      if (sh_acc > ACC_W'(64'sh7FFFFFFF)) begin
         sat_val = 32'sh7FFFFFFF;
      end else if (sh_acc < -ACC_W'(64'sh80000000)) begin
         sat_val = 32'sh80000000;
      end else begin
         sat_val  = sh_acc[31:0];
         sat_flag = 1'b0;
      end
   end

   assign out_load = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign row_done = ({1'b0, k_ff} == l_ff - 4'd1);
   assign run_done = row_done && ({1'b0, i_ff} == n_ff - 4'd1);

   // Sequencer: feed rows of A, wait for the chain, emit the row of C.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         inj_ff.valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
         i_ff         <= 3'd0;
         j_ff         <= 3'd0;
         k_ff         <= 3'd0;
      end else begin
         inj_ff.valid <= 1'b0;
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_LOAD: begin
               if (accept && req_start_after) begin
                  n_ff     <= n_in;
                  p_ff     <= p_in;
                  l_ff     <= l_in;
                  i_ff     <= 3'd0;
                  j_ff     <= 3'd0;
                  state_ff <= S_FEED;
               end
            end
            S_FEED: begin
               inj_ff.valid <= 1'b1;
               inj_ff.first <= (j_ff == 3'd0);
               inj_ff.last  <= ({1'b0, j_ff} == p_ff - 4'd1);
               inj_ff.j     <= j_ff;
               if ({1'b0, j_ff} == p_ff - 4'd1) begin
                  state_ff <= S_WAIT;
               end else begin
                  j_ff <= j_ff + 3'd1;
               end
            end
            S_WAIT: begin
               if (done_vec[CW'(l_ff - 4'd1)]) begin
                  k_ff     <= 3'd0;
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_load) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_row_ff   <= i_ff;
                  rsp_col_ff   <= k_ff;
                  rsp_val_ff   <= sat_val;
                  rsp_sat_ff   <= sat_flag;
                  rsp_last_ff  <= run_done;
                  k_ff         <= k_ff + 3'd1;
                  if (run_done) begin
                     state_ff <= S_LOAD;
                  end else if (row_done) begin
                     i_ff     <= i_ff + 3'd1;
                     j_ff     <= 3'd0;
                     state_ff <= S_FEED;
                  end
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_row       = rsp_row_ff;
   assign rsp_out_col       = rsp_col_ff;
   assign rsp_product_value = rsp_val_ff;
   assign rsp_saturated     = rsp_sat_ff;
   assign rsp_last_of_run   = rsp_last_ff;

   // A start item holds off the input until the product is out.
   `ASSERT_NEXT(a_start_stalls, clock, reset, accept && req_start_after, req_stall)
   // Once the final item of a run is taken, nothing more is offered.
   `ASSERT_NEXT(a_quiet_after_last, clock, reset, rsp_valid && rsp_last_of_run && !rsp_stall, !rsp_valid)
   // The last used cell finishes a row only while the sequencer waits for it.
   `ASSERT_IMPLIES(a_done_in_wait, clock, reset, state_ff != S_LOAD && done_vec[CW'(l_ff - 4'd1)], state_ff == S_WAIT)

endmodule
`default_nettype wire

// ===== dv/mme_tb_pkg.sv =====
// Register indexes shared by the matrix multiply engine testbench files.
`timescale 1ns / 1ps
package mme_tb_pkg;

   typedef enum logic [1:0] {
      REG_ROWS_A    = 2'd0,
      REG_INNER_DIM = 2'd1,
      REG_COLS_B    = 2'd2,
      REG_UNUSED    = 2'd3
   } csr_reg_type;

   localparam int STORE_DIM = 8;

endpackage

// ===== dv/mme_checker.sv =====
// Checker that predicts the matrix product and compares every result item.
`timescale 1ns / 1ps
module mme_checker import mme_tb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_kind,
   input  logic [2:0]         req_row_index,
   input  logic [2:0]         req_col_index,
   input  logic signed [31:0] req_element_value,
   input  logic               req_start_after,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [2:0]         rsp_out_row,
   input  logic [2:0]         rsp_out_col,
   input  logic signed [31:0] rsp_product_value,
   input  logic               rsp_saturated,
   input  logic               rsp_last_of_run,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [3:0]         csr_data,
   output int                 fail_count,
   output int                 pending_count
);

   typedef struct {
      logic [2:0]         row;
      logic [2:0]         col;
      logic signed [31:0] value;
      logic               sat;
      logic               last;
   } product_elem_type;

   localparam logic signed [67:0] Q_MAX = 68'sd2147483647;
   localparam logic signed [67:0] Q_MIN = -68'sd2147483648;

   logic signed [31:0] a_store [STORE_DIM*STORE_DIM];
   logic signed [31:0] b_store [STORE_DIM*STORE_DIM];
   logic [3:0]         dim_rows, dim_inner, dim_cols;
   product_elem_type   expected_products[$];

   // A dimension register of zero acts as one, above eight as eight.
   function automatic int clamp_dim(logic [3:0] v);
      if (v == 0) return 1;
      if (v > STORE_DIM) return STORE_DIM;
      return int'(v);
   endfunction

   // Queue every element of C in row-major order.
   task automatic predict_product();
      int n, p, l;
      logic signed [67:0] acc;
      logic signed [67:0] res;
      product_elem_type e;
      n = clamp_dim(dim_rows);
      p = clamp_dim(dim_inner);
      l = clamp_dim(dim_cols);
      for (int i = 0; i < n; i++) begin
         for (int k = 0; k < l; k++) begin
            acc = '0;
            for (int j = 0; j < p; j++) begin
               acc += 68'(a_store[i*STORE_DIM+j]) * 68'(b_store[j*STORE_DIM+k]);
            end
            res = acc >>> 16;
            e.sat = 1'b0;
            if (res > Q_MAX) begin
               res = Q_MAX;
               e.sat = 1'b1;
            end else if (res < Q_MIN) begin
               res = Q_MIN;
               e.sat = 1'b1;
            end
            e.row = 3'(i);
            e.col = 3'(k);
            e.value = res[31:0];
            e.last = (i == n - 1) && (k == l - 1);
            expected_products.push_back(e);
         end
      end
   endtask

   initial begin
      fail_count = 0;
      for (int i = 0; i < STORE_DIM*STORE_DIM; i++) begin
         a_store[i] = '0;
         b_store[i] = '0;
      end
   end

   assign pending_count = expected_products.size();

   // Configuration writes.
   always @(posedge clock) begin
      if (reset) begin
         dim_rows  <= 4'd8;
         dim_inner <= 4'd8;
         dim_cols  <= 4'd8;
      end else if (csr_valid && csr_ready) begin
         case (csr_reg_type'(csr_index))
            REG_ROWS_A: begin
               dim_rows <= csr_data;
            end
            REG_INNER_DIM: begin
               dim_inner <= csr_data;
            end
            REG_COLS_B: begin
               dim_cols <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Accepted input items: store the element, then predict if started.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         if (req_kind) b_store[req_row_index*STORE_DIM+req_col_index] = req_element_value;
         else a_store[req_row_index*STORE_DIM+req_col_index] = req_element_value;
         if (req_start_after) predict_product();
      end
   end

   // Accepted result items against the oldest expectation.
   always @(posedge clock) begin
      product_elem_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_products.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result item: row %0d col %0d value %h",
                        rsp_out_row, rsp_out_col, rsp_product_value);
         end else begin
            e = expected_products.pop_front();
            if (rsp_out_row !== e.row || rsp_out_col !== e.col ||
                rsp_product_value !== e.value || rsp_saturated !== e.sat ||
                rsp_last_of_run !== e.last) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: exp %0d,%0d %h sat %b last %b, got %0d,%0d %h sat %b last %b",
                           e.row, e.col, e.value, e.sat, e.last, rsp_out_row,
                           rsp_out_col, rsp_product_value, rsp_saturated,
                           rsp_last_of_run);
            end
         end
      end
   end

endmodule

// ===== dv/tb.sv =====
// Testbench top: stimulus, idling and verdict for the matrix multiply engine.
`timescale 1ns / 1ps
module tb import mme_tb_pkg::*;;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 400;

   logic               clock, reset;
   logic               req_valid, req_stall, req_kind, req_start_after;
   logic [2:0]         req_row_index, req_col_index;
   logic signed [31:0] req_element_value;
   logic               rsp_valid, rsp_stall, rsp_saturated, rsp_last_of_run;
   logic [2:0]         rsp_out_row, rsp_out_col;
   logic signed [31:0] rsp_product_value;
   logic               csr_valid, csr_ready;
   logic [1:0]         csr_index;
   logic [3:0]         csr_data;
   int                 fail_count, pending_count;

   bit                 idle_on = 1'b1;
   int                 hold_token = 0;
   int                 hold_seen = 0;
   int                 hold_left = 0;
   int                 quiet_cycles = 0;
   int                 eff_rows = 8, eff_inner = 8, eff_cols = 8;
   bit                 a_loaded [STORE_DIM*STORE_DIM];
   bit                 b_loaded [STORE_DIM*STORE_DIM];

   matrix_multiply_engine_top u_top (.*);

   mme_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // Result-side stalls: random, none, or a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(99) < 37);
      end
   end

   // Watchdog on cycles with no accepted item on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int clamp_dim(logic [3:0] v);
      if (v == 0) return 1;
      if (v > STORE_DIM) return STORE_DIM;
      return int'(v);
   endfunction

   function automatic logic signed [31:0] rand_element();
      case ($urandom_range(4))
         0: return $urandom();
         1: return 32'($urandom_range(262143)) - 32'sd131072;
         2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         default: return 32'($urandom_range(32767)) - 32'sd16384;
      endcase
   endfunction

   // Present one item and hold it until the block takes it.
   task automatic send_item(logic kind, logic [2:0] row, logic [2:0] col,
                            logic signed [31:0] value, logic start);
      while (idle_on && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_row_index <= row;
      req_col_index <= col;
      req_element_value <= value;
      req_start_after <= start;
      do @(posedge clock); while (req_stall);
      if (kind) b_loaded[row*STORE_DIM+col] = 1'b1;
      else a_loaded[row*STORE_DIM+col] = 1'b1;
   endtask

   // Load every entry the product will read that was never written.
   task automatic load_missing();
      for (int i = 0; i < eff_rows; i++)
         for (int j = 0; j < eff_inner; j++)
            if (!a_loaded[i*STORE_DIM+j])
               send_item(1'b0, 3'(i), 3'(j), rand_element(), 1'b0);
      for (int j = 0; j < eff_inner; j++)
         for (int k = 0; k < eff_cols; k++)
            if (!b_loaded[j*STORE_DIM+k])
               send_item(1'b1, 3'(j), 3'(k), rand_element(), 1'b0);
   endtask

   task automatic start_product(logic kind, logic [2:0] row, logic [2:0] col,
                                logic signed [31:0] value);
      load_missing();
      send_item(kind, row, col, value, 1'b1);
   endtask

   // One register write, after which the channel goes idle.
   task automatic csr_write(csr_reg_type idx, logic [3:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_ROWS_A: eff_rows = clamp_dim(value);
         REG_INNER_DIM: eff_inner = clamp_dim(value);
         REG_COLS_B: eff_cols = clamp_dim(value);
         default: ;
      endcase
   endtask

   // Let every expected result drain and the block settle before new settings.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_dims(logic [3:0] r, logic [3:0] p, logic [3:0] c);
      drain();
      csr_write(REG_ROWS_A, r);
      csr_write(REG_INNER_DIM, p);
      csr_write(REG_COLS_B, c);
   endtask

   // Random loads with content of all kinds, started now and then.
   task automatic random_phase(int count);
      logic [2:0] r, c;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 75) begin
            r = 3'($urandom_range(eff_inner > eff_rows ? eff_inner - 1 : eff_rows - 1));
            c = 3'($urandom_range(eff_inner > eff_cols ? eff_inner - 1 : eff_cols - 1));
         end else begin
            r = 3'($urandom_range(7));
            c = 3'($urandom_range(7));
         end
         if ($urandom_range(99) < 9)
            start_product(1'($urandom_range(1)), r, c, rand_element());
         else
            send_item(1'($urandom_range(1)), r, c, rand_element(), 1'b0);
      end
      start_product(1'($urandom_range(1)), 3'd0, 3'd0, rand_element());
   endtask

   initial begin
      int verdict_wait;
      req_valid = 1'b0;
      req_kind = 1'b0;
      req_row_index = '0;
      req_col_index = '0;
      req_element_value = '0;
      req_start_after = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      foreach (a_loaded[i]) begin
         a_loaded[i] = 1'b0;
         b_loaded[i] = 1'b0;
      end
      @(negedge reset);
      @(posedge clock);

      // Directed: one-by-one products at the value extremes and with rounding, zero dimensions, then a 2x3x4 product.
      set_dims(4'd1, 4'd1, 4'd1);
      csr_write(REG_UNUSED, 4'd2);
      send_item(1'b0, 3'd0, 3'd0, 32'sh7fffffff, 1'b0);
      send_item(1'b1, 3'd0, 3'd0, 32'sh7fffffff, 1'b1);
      send_item(1'b0, 3'd0, 3'd0, 32'sh80000000, 1'b1);
      send_item(1'b1, 3'd0, 3'd0, 32'sh80000000, 1'b1);
      send_item(1'b1, 3'd0, 3'd0, 32'sh00000001, 1'b0);
      send_item(1'b0, 3'd0, 3'd0, -32'sd1, 1'b1);
      send_item(1'b0, 3'd0, 3'd0, 32'sh00010000, 1'b1);
      send_item(1'b1, 3'd7, 3'd7, 32'sh12345678, 1'b0);
      send_item(1'b0, 3'd7, 3'd7, -32'sd65536, 1'b1);
      set_dims(4'd0, 4'd0, 4'd0);
      send_item(1'b1, 3'd0, 3'd0, 32'sh7fffffff, 1'b1);
      set_dims(4'd2, 4'd3, 4'd4);
      start_product(1'b0, 3'd1, 3'd2, 32'sh7fffffff);

      // Random phases across several settings, the extremes among them.
      set_dims(4'd15, 4'd9, 4'd8);
      random_phase(45);
      set_dims(4'd3, 4'd3, 4'd3);
      idle_on = 1'b0;
      random_phase(40);
      idle_on = 1'b1;
      set_dims(4'd8, 4'd1, 4'd8);
      random_phase(40);

      // Hold the result side off while items keep coming.
      set_dims(4'd4, 4'd4, 4'd4);
      hold_token++;
      random_phase(45);
      set_dims(4'd1, 4'd8, 4'd1);
      random_phase(40);
      set_dims(4'($urandom_range(15)), 4'($urandom_range(15)), 4'($urandom_range(15)));
      random_phase(40);

      drain();
      verdict_wait = 0;
      while (pending_count != 0 && verdict_wait < 5000) begin
         @(posedge clock);
         verdict_wait++;
      end
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/mme_pkg.sv
hw/rtl/mme_cell.sv
hw/rtl/matrix_multiply_engine_top.sv
dv/mme_tb_pkg.sv
dv/mme_checker.sv
dv/tb.sv
